// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rasterizer rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define TLR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tlr assertion failed");

// same-cycle implication
`define TLR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlr implication failed");

`endif

// ----- hdl/tlr_pkg.sv -----
// types and constants of the thick line rasterizer
// no dependencies; used by thick_line_rasterizer, tlr_pixel_checker and tb_top
package tlr_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int COLOR_BITS     = 24;
	localparam int DIM_BITS       = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_X_START        = 3'd0,
		REG_Y_START        = 3'd1,
		REG_X_END          = 3'd2,
		REG_Y_END          = 3'd3,
		REG_HALF_THICKNESS = 3'd4,
		REG_PIXEL_COLOR    = 3'd5,
		REG_BUFFER_WIDTH   = 3'd6,
		REG_BUFFER_HEIGHT  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_VERTICAL = 2'd0,
		MODE_X_MAJOR  = 2'd1,
		MODE_Y_MAJOR  = 2'd2
	} line_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LATCH_DELTA,
		ST_LATCH_MODE,
		ST_LATCH_ORDER,
		ST_EVAL,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_FIN
	} state_t;

endpackage

// ----- hdl/thick_line_rasterizer.sv -----
// thick line rasterizer: one pixel of a thick line per request
// depends on tlr_pkg and assert_macros.svh
//
// usage:
//  cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the endpoints,
//  half thickness, color and clip size; always ready, write only while idle.
//  in channel (in_valid/in_ready, restart): restart=1 latches the line and returns
//  its first pixel, restart=0 returns the next one. one result per request.
//  out channel (out_valid/out_ready): pixel_x, pixel_y, write_enable, color_out,
//  last_pixel. last_pixel is also set on the empty result once the line is done.
// datapath:
//  a sloped pixel walks a shared multiplier twice and then a radix-2 divider that
//  retires one quotient bit per cycle, COORD_BITS+1 quotient bits in all; a restart
//  first passes the states LATCH_DELTA, LATCH_MODE and LATCH_ORDER.
//  vertical and finished lines skip the divider.
//  in_ready is high only while no request is in work.
// reset: clip size 0, half thickness 1, line finished; the first requests return
//  the empty result until a restart.
// stall: a finished result waits in the output register; the next request is
//  taken meanwhile and its result is held back until out_ready frees the register.
`include "assert_macros.svh"

module thick_line_rasterizer #(
	parameter int COORD_BITS     = 16,
	parameter int THICKNESS_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tlr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_BITS:0]          pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic                                write_enable,
	output logic [tlr_pkg::COLOR_BITS-1:0]      color_out,
	output logic                                last_pixel
);

	localparam int W    = COORD_BITS;
	localparam int T    = THICKNESS_BITS;
	localparam int DW   = W + 1;
	localparam int PRW  = 2 * W + 2;
	localparam int NW   = 2 * W + 3;
	localparam int QW   = W + 1;
	localparam int RW   = W + 2;
	localparam int CW   = $clog2(QW);
	localparam int KW   = T + 1;
	localparam int PW   = ((W > T) ? W : T) + 3;
	localparam int CMPW = (PW > tlr_pkg::DIM_BITS) ? PW : tlr_pkg::DIM_BITS + 1;

	// configuration
	logic signed [W-1:0]               x_start_q, y_start_q, x_end_q, y_end_q;
	logic [T-1:0]                      half_q;
	logic [tlr_pkg::COLOR_BITS-1:0]    color_q;
	logic [tlr_pkg::DIM_BITS-1:0]      bw_q, bh_q;

	// line state
	tlr_pkg::state_t                   state_q, state_d;
	tlr_pkg::line_mode_t               mode_q, mode_new;
	logic signed [DW-1:0]              dx_q, dy_q, dmaj_q, dmin_q;
	logic signed [W-1:0]               x1_q, y1_q, x2_q, y2_q;
	logic signed [W-1:0]               m_q;
	logic signed [KW-1:0]              k_q;
	logic                              finished_q;

	// shared arithmetic
	logic signed [PRW-1:0]             prod_q, acc_q, mul_p;
	logic signed [DW-1:0]              mul_a, mul_b, offs_q;
	logic signed [NW-1:0]              num_q;
	logic [NW-1:0]                     mag;
	logic                              neg_q;
	logic [RW-1:0]                     rem_q, shifted, dvs;
	logic                              ge;
	logic [QW-1:0]                     lo_q, quo_q;
	logic [CW-1:0]                     cnt_q;
	logic signed [W+1:0]               qs_q;

	// output register
	logic                              out_valid_q;
	logic signed [W:0]                 px_q, py_q;
	logic                              we_q, last_q;
	logic [tlr_pkg::COLOR_BITS-1:0]    col_q;

	// combinational helpers
	logic [DW-1:0]                     adx, ady;
	logic                              sw;
	logic signed [W-1:0]               x1n, y1n, x2n, y2n;
	logic signed [DW-1:0]              dxo, dyo;
	logic signed [W-1:0]               minor1, major1, lo, hi;
	logic signed [PW-1:0]              base, kx, minor, px_f, py_f;
	logic signed [CMPW-1:0]            px_c, py_c;
	logic                              we_f;
	logic signed [DW-1:0]              m_inc;
	logic signed [KW:0]                k_inc, half_ext;
	logic                              span_more, last_f, out_free;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == tlr_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign write_enable = we_q;
	assign color_out    = col_q;
	assign last_pixel   = last_q;
	assign out_free     = !out_valid_q || out_ready;

	// mode select and endpoint ordering
	assign adx = $unsigned(dx_q[DW-1] ? -dx_q : dx_q);
	assign ady = $unsigned(dy_q[DW-1] ? -dy_q : dy_q);
	always_comb begin
		if (dx_q == '0)
			mode_new = tlr_pkg::MODE_VERTICAL;
		else if (ady < adx)
			mode_new = tlr_pkg::MODE_X_MAJOR;
		else
			mode_new = tlr_pkg::MODE_Y_MAJOR;
	end
	assign sw  = (mode_q == tlr_pkg::MODE_X_MAJOR) ? dx_q[DW-1] : dy_q[DW-1];
	assign x1n = sw ? x_end_q : x_start_q;
	assign y1n = sw ? y_end_q : y_start_q;
	assign x2n = sw ? x_start_q : x_end_q;
	assign y2n = sw ? y_start_q : y_end_q;
	assign dxo = sw ? -dx_q : dx_q;
	assign dyo = sw ? -dy_q : dy_q;

	// minor endpoint and major start of the current mode
	assign minor1 = (mode_q == tlr_pkg::MODE_X_MAJOR) ? y1_q : x1_q;
	assign major1 = (mode_q == tlr_pkg::MODE_X_MAJOR) ? x1_q : y1_q;
	assign lo     = major1;
	assign hi     = (mode_q == tlr_pkg::MODE_X_MAJOR) ? x2_q : y2_q;

	// one shared multiplier: minor1*dmaj, then dmin*(m-major1)
	assign mul_a = (state_q == tlr_pkg::ST_MUL_A) ? DW'(minor1) : dmin_q;
	assign mul_b = (state_q == tlr_pkg::ST_MUL_A) ? dmaj_q : offs_q;
	assign mul_p = mul_a * mul_b;

	// restoring divider step on magnitudes
	assign mag     = $unsigned(num_q[NW-1] ? -num_q : num_q);
	assign shifted = {rem_q[RW-2:0], lo_q[QW-1]};
	assign dvs     = RW'($unsigned(dmaj_q));
	assign ge      = (shifted >= dvs);

	// pixel position and clip
	assign base  = (mode_q == tlr_pkg::MODE_VERTICAL) ? PW'(x1_q) : PW'(qs_q);
	assign kx    = PW'(k_q);
	assign minor = (mode_q == tlr_pkg::MODE_Y_MAJOR) ? base - kx : base + kx;
	assign px_f  = (mode_q == tlr_pkg::MODE_X_MAJOR) ? PW'(m_q) : minor;
	assign py_f  = (mode_q == tlr_pkg::MODE_X_MAJOR) ? minor : PW'(m_q);
	assign px_c  = CMPW'(px_f);
	assign py_c  = CMPW'(py_f);
	assign we_f  = !px_c[CMPW-1] && ($unsigned(px_c) < CMPW'(bw_q))
		&& !py_c[CMPW-1] && ($unsigned(py_c) < CMPW'(bh_q));

	// walk order: major position inside, offset pass outside
	assign m_inc     = DW'(m_q) + 2'sd1;
	assign span_more = (m_inc < DW'(hi));
	assign k_inc     = (KW+1)'(k_q) + 2'sd1;
	assign half_ext  = $signed({2'b00, half_q});
	assign last_f    = !span_more && (k_inc >= half_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= '0;
			y_start_q <= '0;
			x_end_q   <= '0;
			y_end_q   <= '0;
			half_q    <= T'(1);
			color_q   <= '0;
			bw_q      <= '0;
			bh_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tlr_pkg::REG_X_START:        x_start_q <= $signed(cfg_data[W-1:0]);
				tlr_pkg::REG_Y_START:        y_start_q <= $signed(cfg_data[W-1:0]);
				tlr_pkg::REG_X_END:          x_end_q   <= $signed(cfg_data[W-1:0]);
				tlr_pkg::REG_Y_END:          y_end_q   <= $signed(cfg_data[W-1:0]);
				tlr_pkg::REG_HALF_THICKNESS: half_q    <= cfg_data[T-1:0];
				tlr_pkg::REG_PIXEL_COLOR:    color_q   <= cfg_data[tlr_pkg::COLOR_BITS-1:0];
				tlr_pkg::REG_BUFFER_WIDTH:   bw_q      <= cfg_data[tlr_pkg::DIM_BITS-1:0];
				tlr_pkg::REG_BUFFER_HEIGHT:  bh_q      <= cfg_data[tlr_pkg::DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tlr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlr_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = restart ? tlr_pkg::ST_LATCH_DELTA : tlr_pkg::ST_EVAL;
			end
			tlr_pkg::ST_LATCH_DELTA: state_d = tlr_pkg::ST_LATCH_MODE;
			tlr_pkg::ST_LATCH_MODE:  state_d = tlr_pkg::ST_LATCH_ORDER;
			tlr_pkg::ST_LATCH_ORDER: state_d = tlr_pkg::ST_EVAL;
			tlr_pkg::ST_EVAL: begin
				if (finished_q || mode_q == tlr_pkg::MODE_VERTICAL)
					state_d = tlr_pkg::ST_FIN;
				else
					state_d = tlr_pkg::ST_MUL_A;
			end
			tlr_pkg::ST_MUL_A: state_d = tlr_pkg::ST_MUL_B;
			tlr_pkg::ST_MUL_B: state_d = tlr_pkg::ST_SUM;
			tlr_pkg::ST_SUM:   state_d = tlr_pkg::ST_ABS;
			tlr_pkg::ST_ABS:   state_d = tlr_pkg::ST_DIV;
			tlr_pkg::ST_DIV: begin
				if (cnt_q == CW'(QW - 1))
					state_d = tlr_pkg::ST_SIGN;
			end
			tlr_pkg::ST_SIGN: state_d = tlr_pkg::ST_FIN;
			tlr_pkg::ST_FIN: begin
				if (out_free)
					state_d = tlr_pkg::ST_IDLE;
			end
			default: state_d = tlr_pkg::ST_IDLE;
		endcase
	end

	// line state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tlr_pkg::MODE_VERTICAL;
			k_q         <= '0;
			m_q         <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			x2_q        <= '0;
			y2_q        <= '0;
			finished_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				tlr_pkg::ST_LATCH_MODE: mode_q <= mode_new;
				tlr_pkg::ST_LATCH_ORDER: begin
					x1_q <= x1n;
					y1_q <= y1n;
					x2_q <= x2n;
					y2_q <= y2n;
					m_q  <= (mode_q == tlr_pkg::MODE_X_MAJOR) ? x1n : y1n;
					k_q  <= -$signed({1'b0, half_q});
					finished_q <= (mode_q != tlr_pkg::MODE_X_MAJOR && dy_q == '0)
						|| (half_q == '0);
				end
				tlr_pkg::ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!finished_q) begin
							if (span_more) begin
								m_q <= m_inc[W-1:0];
							end else begin
								k_q <= k_inc[KW-1:0];
								m_q <= lo;
							end
							if (last_f)
								finished_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tlr_pkg::ST_LATCH_DELTA: begin
				dx_q <= DW'(x_end_q) - DW'(x_start_q);
				dy_q <= DW'(y_end_q) - DW'(y_start_q);
			end
			tlr_pkg::ST_LATCH_ORDER: begin
				dmaj_q <= (mode_q == tlr_pkg::MODE_X_MAJOR) ? dxo : dyo;
				dmin_q <= (mode_q == tlr_pkg::MODE_X_MAJOR) ? dyo : dxo;
			end
			tlr_pkg::ST_MUL_A: begin
				prod_q <= mul_p;
				offs_q <= DW'(m_q) - DW'(major1);
			end
			tlr_pkg::ST_MUL_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			tlr_pkg::ST_SUM: num_q <= NW'(acc_q) + NW'(prod_q);
			tlr_pkg::ST_ABS: begin
				neg_q <= num_q[NW-1];
				rem_q <= mag[NW-1:QW];
				lo_q  <= mag[QW-1:0];
				cnt_q <= '0;
			end
			tlr_pkg::ST_DIV: begin
				rem_q <= ge ? shifted - dvs : shifted;
				lo_q  <= {lo_q[QW-2:0], 1'b0};
				quo_q <= {quo_q[QW-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
			end
			tlr_pkg::ST_SIGN: begin
				qs_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
			tlr_pkg::ST_FIN: begin
				if (out_free) begin
					if (finished_q) begin
						px_q   <= '0;
						py_q   <= '0;
						we_q   <= 1'b0;
						col_q  <= '0;
						last_q <= 1'b1;
					end else begin
						px_q   <= px_f[W:0];
						py_q   <= py_f[W:0];
						we_q   <= we_f;
						col_q  <= color_q;
						last_q <= last_f;
					end
				end
			end
			default: ;
		endcase
	end

	// the partial remainder never reaches the divisor
	`TLR_ASSERT_IMPL(a_div_rem_below, state_q == tlr_pkg::ST_DIV, rem_q < dvs)
	// a sloped pixel never divides by a non-positive delta
	`TLR_ASSERT_IMPL(a_div_nonzero, state_q == tlr_pkg::ST_MUL_A, dmaj_q > 0)
	// an open line keeps its major position inside the span
	`TLR_ASSERT_IMPL(a_major_in_span, (state_q == tlr_pkg::ST_EVAL) && !finished_q,
		(m_q >= lo) && (m_q < hi))
	// results are only produced from the final state
	`TLR_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == tlr_pkg::ST_FIN))

endmodule

// ----- tb/tlr_pixel_checker.sv -----
// pixel checker for the thick line rasterizer: mirrors the config writes, predicts
// the pixel of every accepted request and compares each delivered pixel in order
// depends on tlr_pkg
module tlr_pixel_checker #(
	parameter int COORD_BITS     = 16,
	parameter int THICKNESS_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [tlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tlr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               restart,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [COORD_BITS:0]                pixel_x,
	input  logic [COORD_BITS:0]                pixel_y,
	input  logic                               write_enable,
	input  logic [tlr_pkg::COLOR_BITS-1:0]     color_out,
	input  logic                               last_pixel,
	output int                                 mismatch_count,
	output int                                 pixels_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COORD_BITS:0]            x;
		logic [COORD_BITS:0]            y;
		logic                           we;
		logic [tlr_pkg::COLOR_BITS-1:0] color;
		logic                           last;
	} pixel_t;

	pixel_t pending_pixels[$];

	// register copies
	longint                         x_start_q, y_start_q, x_end_q, y_end_q;
	int unsigned                    half_q;
	logic [tlr_pkg::COLOR_BITS-1:0] color_q;
	longint                         width_q, height_q;

	// walk state
	tlr_pkg::line_mode_t mode_q;
	longint              offset_q, major_q;
	longint              ox1, oy1, ox2, oy2;
	bit                  done_q;

	function automatic longint coord_of(logic [tlr_pkg::CFG_DATA_BITS-1:0] d);
		logic signed [COORD_BITS-1:0] c;
		c = d[COORD_BITS-1:0];
		return c;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic latch_line();
		longint x1, y1, x2, y2, dx, dy, t, lo, hi;
		bit     swap;
		x1 = x_start_q;
		y1 = y_start_q;
		x2 = x_end_q;
		y2 = y_end_q;
		dx = x2 - x1;
		dy = y2 - y1;
		if (dx == 0)
			mode_q = tlr_pkg::MODE_VERTICAL;
		else if (magnitude(dy) < magnitude(dx))
			mode_q = tlr_pkg::MODE_X_MAJOR;
		else
			mode_q = tlr_pkg::MODE_Y_MAJOR;
		swap = (mode_q == tlr_pkg::MODE_X_MAJOR) ? (x2 < x1) : (y2 < y1);
		if (swap) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		ox1 = x1;
		oy1 = y1;
		ox2 = x2;
		oy2 = y2;
		lo = (mode_q == tlr_pkg::MODE_X_MAJOR) ? x1 : y1;
		hi = (mode_q == tlr_pkg::MODE_X_MAJOR) ? x2 : y2;
		major_q = lo;
		offset_q = -longint'(half_q);
		done_q = (hi <= lo) || (half_q == 0);
	endtask

	task automatic rasterize_next(input logic fresh, output pixel_t pix);
		longint px, py, hi, num, span;
		if (fresh)
			latch_line();
		pix = '0;
		if (done_q) begin
			pix.last = 1'b1;
			return;
		end
		case (mode_q)
			tlr_pkg::MODE_VERTICAL: begin
				px = ox1 + offset_q;
				py = major_q;
				hi = oy2;
			end
			tlr_pkg::MODE_X_MAJOR: begin
				span = ox2 - ox1;
				num = oy1 * span + (oy2 - oy1) * (major_q - ox1);
				px = major_q;
				py = ((span != 0) ? num / span : 0) + offset_q;
				hi = ox2;
			end
			default: begin
				span = oy2 - oy1;
				num = ox1 * span + (ox2 - ox1) * (major_q - oy1);
				px = ((span != 0) ? num / span : 0) - offset_q;
				py = major_q;
				hi = oy2;
			end
		endcase
		pix.x = px[COORD_BITS:0];
		pix.y = py[COORD_BITS:0];
		pix.we = (px >= 0) && (py >= 0) && (px < width_q) && (py < height_q);
		pix.color = color_q;
		// inner loop walks the major axis, outer loop steps the offset
		if (major_q + 1 < hi) begin
			major_q++;
			pix.last = 1'b0;
		end else begin
			pix.last = (offset_q + 1 >= longint'(half_q));
			offset_q++;
			major_q = (mode_q == tlr_pkg::MODE_X_MAJOR) ? ox1 : oy1;
		end
		if (pix.last)
			done_q = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t got, want;
		if (!arst_n) begin
			x_start_q = 0;
			y_start_q = 0;
			x_end_q = 0;
			y_end_q = 0;
			half_q = 1;
			color_q = '0;
			width_q = 0;
			height_q = 0;
			mode_q = tlr_pkg::MODE_VERTICAL;
			offset_q = 0;
			major_q = 0;
			ox1 = 0;
			oy1 = 0;
			ox2 = 0;
			oy2 = 0;
			done_q = 1'b1;
			mismatch_count = 0;
			pending_pixels.delete();
			pixels_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tlr_pkg::cfg_reg_t'(cfg_index))
					tlr_pkg::REG_X_START:        x_start_q = coord_of(cfg_data);
					tlr_pkg::REG_Y_START:        y_start_q = coord_of(cfg_data);
					tlr_pkg::REG_X_END:          x_end_q = coord_of(cfg_data);
					tlr_pkg::REG_Y_END:          y_end_q = coord_of(cfg_data);
					tlr_pkg::REG_HALF_THICKNESS: half_q = cfg_data[THICKNESS_BITS-1:0];
					tlr_pkg::REG_PIXEL_COLOR:    color_q = cfg_data[tlr_pkg::COLOR_BITS-1:0];
					tlr_pkg::REG_BUFFER_WIDTH:   width_q = cfg_data[tlr_pkg::DIM_BITS-1:0];
					tlr_pkg::REG_BUFFER_HEIGHT:  height_q = cfg_data[tlr_pkg::DIM_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.x = pixel_x;
				got.y = pixel_y;
				got.we = write_enable;
				got.color = color_out;
				got.last = last_pixel;
				if (pending_pixels.size() == 0) begin
					report_mismatch("pixel delivered with no request waiting");
				end else begin
					want = pending_pixels.pop_front();
					if (got.x !== want.x)
						report_mismatch($sformatf("pixel_x %0d, expected %0d",
							$signed(got.x), $signed(want.x)));
					if (got.y !== want.y)
						report_mismatch($sformatf("pixel_y %0d, expected %0d",
							$signed(got.y), $signed(want.y)));
					if (got.we !== want.we)
						report_mismatch($sformatf("write_enable %b, expected %b",
							got.we, want.we));
					if (got.color !== want.color)
						report_mismatch($sformatf("color_out %h, expected %h",
							got.color, want.color));
					if (got.last !== want.last)
						report_mismatch($sformatf("last_pixel %b, expected %b",
							got.last, want.last));
				end
			end
			if (in_valid && in_ready) begin
				rasterize_next(restart, want);
				pending_pixels = {pending_pixels, want};
			end
			pixels_owed <= pending_pixels.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// top of the thick line rasterizer testbench: clock, reset, config and pixel
// requests with random pacing; the verdict comes from tlr_pixel_checker
// depends on tlr_pkg, thick_line_rasterizer and tlr_pixel_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS     = 16;
	localparam int THICKNESS_BITS = 8;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int DIRECTED_ITEMS = 25;
	// worst quiet stretch is a gap plus a request in work plus a few stall runs
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [tlr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [tlr_pkg::CFG_DATA_BITS-1:0]  cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic                               restart;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [COORD_BITS:0]                pixel_x;
	logic [COORD_BITS:0]                pixel_y;
	logic                               write_enable;
	logic [tlr_pkg::COLOR_BITS-1:0]     color_out;
	logic                               last_pixel;

	int mismatch_count;
	int pixels_owed;
	int items_sent = 0;
	int ready_hold = 0;
	int quiet_cycles = 0;
	bit steady;

	always #6ns clk = ~clk;

	thick_line_rasterizer #(
		.COORD_BITS     (COORD_BITS),
		.THICKNESS_BITS (THICKNESS_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.write_enable (write_enable),
		.color_out    (color_out),
		.last_pixel   (last_pixel)
	);

	tlr_pixel_checker #(
		.COORD_BITS     (COORD_BITS),
		.THICKNESS_BITS (THICKNESS_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.write_enable   (write_enable),
		.color_out      (color_out),
		.last_pixel     (last_pixel),
		.mismatch_count (mismatch_count),
		.pixels_owed    (pixels_owed)
	);

	// receiver: runs of ready and stall of random length, or always ready while steady
	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (ready_hold == 0) begin
			out_ready <= ($urandom_range(0, 2) != 0);
			ready_hold <= $urandom_range(0, 30);
		end else begin
			ready_hold <= ready_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
			    (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic wait_drained();
		do @(posedge clk); while (pixels_owed != 0);
	endtask

	task automatic write_reg(input tlr_pkg::cfg_reg_t idx,
			input logic [tlr_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// bits above a register's width carry noise
	task automatic setup_line(input int xs, input int ys, input int xe, input int ye,
			input int half, input logic [tlr_pkg::COLOR_BITS-1:0] color,
			input int bw, input int bh);
		wait_drained();
		write_reg(tlr_pkg::REG_X_START, {8'($urandom), 16'(xs)});
		write_reg(tlr_pkg::REG_Y_START, {8'($urandom), 16'(ys)});
		write_reg(tlr_pkg::REG_X_END, {8'($urandom), 16'(xe)});
		write_reg(tlr_pkg::REG_Y_END, {8'($urandom), 16'(ye)});
		write_reg(tlr_pkg::REG_HALF_THICKNESS, {16'($urandom), 8'(half)});
		write_reg(tlr_pkg::REG_PIXEL_COLOR, color);
		write_reg(tlr_pkg::REG_BUFFER_WIDTH, {8'($urandom), 16'(bw)});
		write_reg(tlr_pkg::REG_BUFFER_HEIGHT, {8'($urandom), 16'(bh)});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_request(input logic rs);
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// first request restarts if fresh; later ones advance, with restarts as noise
	task automatic draw_line(input int count, input bit fresh, input int noise_pct);
		wait_drained();
		for (int i = 0; i < count; i++) begin
			if (i > 0 && !steady) begin
				case ($urandom_range(0, 15))
					0, 1, 2: begin
						in_valid <= 1'b0;
						repeat ($urandom_range(1, 24)) @(posedge clk);
					end
					3: begin
						in_valid <= 1'b0;
						wait_drained();
					end
					default: ;
				endcase
			end
			send_request((i == 0) ? fresh : ($urandom_range(0, 99) < noise_pct));
		end
		in_valid <= 1'b0;
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 7))
			0: return ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 3))
				: -32768 + int'($urandom_range(0, 3));
			1: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 60)) - 20;
		endcase
	endfunction

	function automatic int pick_delta();
		if ($urandom_range(0, 9) == 0)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom_range(0, 24)) - 12;
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 65535;
			2: return int'($urandom_range(0, 65535));
			default: return int'($urandom_range(0, 48));
		endcase
	endfunction

	task automatic roll_line();
		int xs, ys, dx, dy, xe, ye, half;
		xs = pick_coord();
		ys = pick_coord();
		dx = pick_delta();
		dy = pick_delta();
		case ($urandom_range(0, 5))
			0: dx = 0;
			1: dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
			default: ;
		endcase
		// reflect the far end back into the coordinate range
		xe = xs + dx;
		if (xe > 32767 || xe < -32768)
			xe = xs - dx;
		ye = ys + dy;
		if (ye > 32767 || ye < -32768)
			ye = ys - dy;
		case ($urandom_range(0, 9))
			0: half = 0;
			1: half = 255;
			2: half = $urandom_range(0, 255);
			default: half = $urandom_range(1, 3);
		endcase
		setup_line(xs, ys, xe, ye, half, 24'($urandom), pick_size(), pick_size());
	endtask

	initial begin : stimulus
		bit reload;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= tlr_pkg::REG_X_START;
		cfg_data <= '0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		steady <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// nothing latched yet, then a restart of the all-zero line
		draw_line(1, 1'b0, 0);
		draw_line(1, 1'b1, 0);
		// vertical, endpoints reversed, bottom row clipped; runs past its end
		setup_line(5, 4, 5, 2, 1, 24'hFFFFFF, 8, 3);
		draw_line(5, 1'b1, 0);
		// x-major walking left to right after the swap
		setup_line(4, 3, -2, 1, 1, 24'h00A5C3, 3, 3);
		draw_line(4, 1'b1, 0);
		// equal deltas fall into y-major
		setup_line(0, 0, 3, -3, 2, 24'h5A5A5A, 4, 4);
		draw_line(3, 1'b1, 0);
		// zero thickness gives an empty line
		setup_line(1, 1, 9, 5, 0, 24'h3C3C3C, 16, 16);
		draw_line(1, 1'b1, 0);
		// coordinate extremes with the widest pen and the largest buffer
		setup_line(-32768, 32767, 32767, -32768, 255, 24'h000000, 65535, 65535);
		draw_line(3, 1'b1, 0);
		setup_line(-32768, -32768, 32767, 32766, 255, 24'hFFFFFF, 65535, 65535);
		draw_line(2, 1'b1, 0);
		// thickness narrowed mid-line without a restart
		setup_line(7, 0, 7, 1, 3, 24'h123456, 16, 16);
		draw_line(2, 1'b1, 0);
		setup_line(7, 0, 7, 1, 1, 24'h654321, 16, 16);
		draw_line(3, 1'b0, 0);

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			steady <= ($urandom_range(0, 5) == 0);
			reload = ($urandom_range(0, 4) != 0);
			if (reload)
				roll_line();
			draw_line($urandom_range(1, 40),
				reload ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 1) != 0), 6);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tlr_pkg.sv
hdl/thick_line_rasterizer.sv
tb/tlr_pixel_checker.sv
tb/tb_top.sv
